### hdl/gep_pkg.sv
package gep_pkg;

  localparam int COUNT_W = 14;
  localparam int RATE_W = 48;
  localparam int ACC_W = 80;
  localparam int NUM_EVENTS = 11;
  localparam int NUM_CMP = 5;
  localparam int LAST_OP = 15;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [3:0] NO_EVENT = 4'd11;
  localparam logic [3:0] LAST_EVENT = 4'd10;

  // Compartment codes.
  localparam logic [2:0] CMP_S = 3'd0;
  localparam logic [2:0] CMP_I1 = 3'd1;
  localparam logic [2:0] CMP_R = 3'd2;
  localparam logic [2:0] CMP_P = 3'd3;
  localparam logic [2:0] CMP_IR = 3'd4;
  localparam logic [2:0] CMP_NONE = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_CONTACT = 3'd0;
  localparam logic [2:0] REG_KAPPA = 3'd1;
  localparam logic [2:0] REG_RECOV = 3'd2;
  localparam logic [2:0] REG_REINF = 3'd3;
  localparam logic [2:0] REG_WANING = 3'd4;
  localparam logic [2:0] REG_BIRTH = 3'd5;
  localparam logic [2:0] REG_DEATH = 3'd6;
  localparam logic [2:0] REG_POPCAP = 3'd7;

  typedef struct packed {
    logic [31:0] contact;
    logic [15:0] kappa;
    logic [31:0] recov;
    logic [31:0] reinf;
    logic [31:0] waning;
    logic [31:0] birth;
    logic [31:0] death;
    logic [COUNT_W-1:0] pop_cap;
  } cfg_t;

  typedef enum logic [1:0] {SH0, SH16, SH32} shift_t;

  typedef enum logic [3:0] {
    A_KAPPA, A_CONTACT, A_TMP, A_RECOV, A_REINF, A_WANING, A_BIRTH, A_DEATH, A_TOTAL
  } a_sel_t;

  typedef enum logic [3:0] {
    B_S, B_I1, B_R, B_P, B_IR, B_KAPPA, B_FORCE, B_POP, B_DRAW
  } b_sel_t;

  typedef enum logic [1:0] {D_FORCE, D_TMP, D_RATE, D_RAN} dst_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    shift_t sh;
    logic two;
    dst_t dst;
    logic [3:0] ridx;
  } op_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic dsel;
    shift_t sh;
  } mac_ctl_t;

  function automatic op_t op_table(input logic [3:0] op);
    op_t o;
    o = '{a: A_DEATH, b: B_S, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd0};
    case (op)
      4'd0: o = '{a: A_KAPPA, b: B_IR, sh: SH0, two: 1'b0, dst: D_FORCE, ridx: 4'd0};
      4'd1: o = '{a: A_CONTACT, b: B_S, sh: SH0, two: 1'b0, dst: D_TMP, ridx: 4'd0};
      4'd2: o = '{a: A_TMP, b: B_FORCE, sh: SH16, two: 1'b1, dst: D_RATE, ridx: 4'd0};
      4'd3: o = '{a: A_CONTACT, b: B_P, sh: SH0, two: 1'b0, dst: D_TMP, ridx: 4'd0};
      4'd4: o = '{a: A_TMP, b: B_KAPPA, sh: SH16, two: 1'b0, dst: D_TMP, ridx: 4'd0};
      4'd5: o = '{a: A_TMP, b: B_FORCE, sh: SH16, two: 1'b1, dst: D_RATE, ridx: 4'd1};
      4'd6: o = '{a: A_RECOV, b: B_I1, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd2};
      4'd7: o = '{a: A_REINF, b: B_IR, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd3};
      4'd8: o = '{a: A_WANING, b: B_R, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd4};
      4'd9: o = '{a: A_BIRTH, b: B_POP, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd5};
      4'd10: o = '{a: A_DEATH, b: B_R, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd6};
      4'd11: o = '{a: A_DEATH, b: B_P, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd7};
      4'd12: o = '{a: A_DEATH, b: B_S, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd8};
      4'd13: o = '{a: A_DEATH, b: B_IR, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd9};
      4'd14: o = '{a: A_DEATH, b: B_I1, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd10};
      4'd15: o = '{a: A_TOTAL, b: B_DRAW, sh: SH32, two: 1'b1, dst: D_RAN, ridx: 4'd0};
      default: o = '{a: A_DEATH, b: B_S, sh: SH0, two: 1'b0, dst: D_RATE, ridx: 4'd0};
    endcase
    return o;
  endfunction

  function automatic logic [2:0] ev_src(input logic [3:0] ev);
    logic [2:0] s;
    case (ev)
      4'd0: s = CMP_S;
      4'd1: s = CMP_P;
      4'd2: s = CMP_I1;
      4'd3: s = CMP_IR;
      4'd4: s = CMP_R;
      4'd6: s = CMP_R;
      4'd7: s = CMP_P;
      4'd8: s = CMP_S;
      4'd9: s = CMP_IR;
      4'd10: s = CMP_I1;
      default: s = CMP_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] ev_dst(input logic [3:0] ev);
    logic [2:0] d;
    case (ev)
      4'd0: d = CMP_I1;
      4'd1: d = CMP_IR;
      4'd2: d = CMP_R;
      4'd3: d = CMP_R;
      4'd4: d = CMP_P;
      4'd5: d = CMP_S;
      default: d = CMP_NONE;
    endcase
    return d;
  endfunction

endpackage

### hdl/gep_cfg.sv
module gep_cfg import gep_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.contact <= 32'd226492;
      cfg_r.kappa <= 16'd27388;
      cfg_r.recov <= 32'd218103808;
      cfg_r.reinf <= 32'd521904293;
      cfg_r.waning <= 32'd3355443;
      cfg_r.birth <= 32'd335544;
      cfg_r.death <= 32'd335544;
      cfg_r.pop_cap <= COUNT_W'(10000);
    end else if (wr_en) begin
      case (wr_index)
        REG_CONTACT: cfg_r.contact <= wr_data;
        REG_KAPPA: cfg_r.kappa <= wr_data[15:0];
        REG_RECOV: cfg_r.recov <= wr_data;
        REG_REINF: cfg_r.reinf <= wr_data;
        REG_WANING: cfg_r.waning <= wr_data;
        REG_BIRTH: cfg_r.birth <= wr_data;
        REG_DEATH: cfg_r.death <= wr_data;
        REG_POPCAP: cfg_r.pop_cap <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/gep_mac.sv
module gep_mac import gep_pkg::*; (
  input  logic              clk,
  input  mac_ctl_t          ctl,
  input  logic [31:0]       init,
  input  logic [RATE_W-1:0] a,
  input  logic [15:0]       digit,
  output logic [RATE_W-1:0] res
);

  // One 48x16 partial product per cycle is added into an 80-bit accumulator while en is set.
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [63:0] prod;
  logic [ACC_W-1:0] prod_sh;
  logic [ACC_W-1:0] shifted;

  assign prod = {16'b0, a} * {48'b0, digit};
  assign prod_sh = ctl.dsel ? {prod, 16'b0} : {16'b0, prod};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = {48'b0, init};
    end else if (ctl.en) begin
      acc_nxt = acc_r + prod_sh;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_comb begin
    case (ctl.sh)
      SH16: shifted = {16'b0, acc_r[ACC_W-1:16]};
      SH32: shifted = {32'b0, acc_r[ACC_W-1:32]};
      default: shifted = acc_r;
    endcase
    res = (shifted[ACC_W-1:RATE_W] != '0) ? RATE_MAX : shifted[RATE_W-1:0];
  end

endmodule

### hdl/gillespie_epidemic_step.sv
// Direct-method event selector for a five-compartment epidemic model.
// Input channel (in_valid / in_stall): a transfer with in_req_type 0 loads the
// five compartment counts; with in_req_type 1 it performs one stochastic step
// using in_uniform_draw as a Q0.32 fraction. Each transfer yields exactly one
// result transfer on the output channel (out_valid / out_stall) carrying the
// chosen event code, the counts after the item, the rate sum and the
// extinction flag. The configuration channel (cfg_valid / cfg_ready) is always
// ready and writes one of eight registers per transfer; write it only
// while the block is idle.
// A load's result is offered in the cycle after its transfer. A step runs
// sixteen multiply operations on one shared 48x16 multiply-accumulate unit,
// one digit per cycle with a write-back after each operation, then walks up
// to eleven rates one per cycle and applies the change.
// in_stall is high from a transfer until its result has been taken, so one
// item is in flight at a time. A stalled result holds its payload.
// Reset clears the counts to zero and returns the registers to defaults.
module gillespie_epidemic_step import gep_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [31:0]        in_uniform_draw,
  input  logic [COUNT_W-1:0] in_load_susceptible,
  input  logic [COUNT_W-1:0] in_load_first_infected,
  input  logic [COUNT_W-1:0] in_load_recovered,
  input  logic [COUNT_W-1:0] in_load_partial,
  input  logic [COUNT_W-1:0] in_load_reinfected,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_event_code,
  output logic [COUNT_W-1:0] out_susceptible,
  output logic [COUNT_W-1:0] out_first_infected,
  output logic [COUNT_W-1:0] out_recovered,
  output logic [COUNT_W-1:0] out_partial,
  output logic [COUNT_W-1:0] out_reinfected,
  output logic [RATE_W-1:0]  out_total_rate,
  output logic               out_extinct,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_WB    = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  cfg_t cfg;
  state_t state_r;
  logic [COUNT_W-1:0] cnt_r [NUM_CMP];
  logic [RATE_W-1:0] rate_r [NUM_EVENTS];
  logic [RATE_W-1:0] tmp_r;
  logic [RATE_W-1:0] total_r;
  logic [RATE_W-1:0] ran_r;
  logic [30:0] force_r;
  logic [31:0] draw_r;
  logic [3:0] op_r;
  logic dsel_r;
  logic [3:0] walk_r;
  logic [3:0] event_r;

  op_t op;
  mac_ctl_t mac_ctl;
  logic [31:0] mac_init;
  logic [RATE_W-1:0] mac_a;
  logic [31:0] b_val;
  logic [15:0] digit;
  logic [RATE_W-1:0] res;
  logic [COUNT_W+2:0] pop;
  logic [COUNT_W-1:0] pop_gated;
  logic [RATE_W:0] total_sum;
  logic in_xfer;
  logic out_xfer;

  assign cfg_ready = 1'b1;

  gep_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign out_xfer = out_valid && !out_stall;

  assign op = op_table(op_r);

  // Births are only possible while the population is below the cap.
  assign pop = {3'b0, cnt_r[0]} + {3'b0, cnt_r[1]} + {3'b0, cnt_r[2]} +
               {3'b0, cnt_r[3]} + {3'b0, cnt_r[4]};
  assign pop_gated = (pop < {3'b0, cfg.pop_cap}) ? pop[COUNT_W-1:0] : '0;

  always_comb begin
    case (op.a)
      A_KAPPA: mac_a = {32'b0, cfg.kappa};
      A_CONTACT: mac_a = {16'b0, cfg.contact};
      A_TMP: mac_a = tmp_r;
      A_RECOV: mac_a = {16'b0, cfg.recov};
      A_REINF: mac_a = {16'b0, cfg.reinf};
      A_WANING: mac_a = {16'b0, cfg.waning};
      A_BIRTH: mac_a = {16'b0, cfg.birth};
      A_DEATH: mac_a = {16'b0, cfg.death};
      A_TOTAL: mac_a = total_r;
      default: mac_a = '0;
    endcase
    case (op.b)
      B_S: b_val = {18'b0, cnt_r[0]};
      B_I1: b_val = {18'b0, cnt_r[1]};
      B_R: b_val = {18'b0, cnt_r[2]};
      B_P: b_val = {18'b0, cnt_r[3]};
      B_IR: b_val = {18'b0, cnt_r[4]};
      B_KAPPA: b_val = {16'b0, cfg.kappa};
      B_FORCE: b_val = {1'b0, force_r};
      B_POP: b_val = {18'b0, pop_gated};
      B_DRAW: b_val = draw_r;
      default: b_val = '0;
    endcase
  end

  assign digit = dsel_r ? b_val[31:16] : b_val[15:0];

  // The force of infection starts from the first-infected count in Q.16;
  // the first operation then adds kappa times the reinfected count.
  always_comb begin
    mac_ctl.clr = 1'b0;
    mac_ctl.en = (state_r == ST_MUL);
    mac_ctl.dsel = dsel_r;
    mac_ctl.sh = op.sh;
    mac_init = '0;
    if (in_xfer) begin
      mac_ctl.clr = 1'b1;
      mac_init = {2'b0, cnt_r[1], 16'b0};
    end else if (state_r == ST_WB) begin
      mac_ctl.clr = 1'b1;
    end
  end

  gep_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .init  (mac_init),
    .a     (mac_a),
    .digit (digit),
    .res   (res)
  );

  // The rate sum saturates at the top of the 48-bit range.
  assign total_sum = {1'b0, total_r} + {1'b0, res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < NUM_CMP; i++) begin
        cnt_r[i] <= '0;
      end
      op_r <= '0;
      dsel_r <= 1'b0;
      walk_r <= '0;
      event_r <= NO_EVENT;
      total_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            event_r <= NO_EVENT;
            total_r <= '0;
            op_r <= '0;
            dsel_r <= 1'b0;
            draw_r <= in_uniform_draw;
            if (in_req_type) begin
              state_r <= ST_MUL;
            end else begin
              cnt_r[0] <= in_load_susceptible;
              cnt_r[1] <= in_load_first_infected;
              cnt_r[2] <= in_load_recovered;
              cnt_r[3] <= in_load_partial;
              cnt_r[4] <= in_load_reinfected;
              state_r <= ST_OUT;
            end
          end
        end
        ST_MUL: begin
          if (op.two && !dsel_r) begin
            dsel_r <= 1'b1;
          end else begin
            state_r <= ST_WB;
          end
        end
        ST_WB: begin
          dsel_r <= 1'b0;
          case (op.dst)
            D_FORCE: force_r <= res[30:0];
            D_TMP: tmp_r <= res;
            D_RATE: begin
              rate_r[op.ridx] <= res;
              total_r <= total_sum[RATE_W] ? RATE_MAX : total_sum[RATE_W-1:0];
            end
            D_RAN: ran_r <= res;
            default: ;
          endcase
          if (op_r == 4'(LAST_OP)) begin
            walk_r <= '0;
            state_r <= ST_WALK;
          end else begin
            op_r <= op_r + 4'd1;
            state_r <= ST_MUL;
          end
        end
        ST_WALK: begin
          // The first rate that exceeds the remaining target is chosen.
          if (ran_r < rate_r[walk_r]) begin
            event_r <= walk_r;
            state_r <= ST_APPLY;
          end else begin
            ran_r <= ran_r - rate_r[walk_r];
            walk_r <= walk_r + 4'd1;
            if (walk_r == LAST_EVENT) begin
              state_r <= ST_APPLY;
            end
          end
        end
        ST_APPLY: begin
          if (event_r != NO_EVENT) begin
            for (int i = 0; i < NUM_CMP; i++) begin
              if (ev_src(event_r) == 3'(i) && cnt_r[i] != '0) begin
                cnt_r[i] <= cnt_r[i] - COUNT_W'(1);
              end
              if (ev_dst(event_r) == 3'(i) && cnt_r[i] != COUNT_MAX) begin
                cnt_r[i] <= cnt_r[i] + COUNT_W'(1);
              end
            end
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_xfer) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_event_code = event_r;
  assign out_susceptible = cnt_r[0];
  assign out_first_infected = cnt_r[1];
  assign out_recovered = cnt_r[2];
  assign out_partial = cnt_r[3];
  assign out_reinfected = cnt_r[4];
  assign out_total_rate = total_r;
  assign out_extinct = (cnt_r[1] == '0) && (cnt_r[4] == '0);

endmodule

### tb/gillespie_epidemic_step_tb.sv
module gillespie_epidemic_step_tb;
  import gep_pkg::*;

  // Expected outcome of one item: event code, counts after the item, rate sum
  // before the step and the extinction flag.
  typedef struct {
    logic [3:0]                ev;
    logic [4:0][COUNT_W-1:0]   cnt;
    logic [RATE_W-1:0]         total;
    logic                      extinct;
  } outcome_t;

  // The scoreboard carries its own copy of the compartment counts and of the
  // rate registers, and predicts one outcome for every accepted input transfer.
  class epidemic_scoreboard;
    outcome_t                pending[$];
    int                      errors;
    logic [31:0]             contact, recov, reinf, waning, birth, death;
    logic [15:0]             kappa;
    logic [COUNT_W-1:0]      pop_cap;
    logic [4:0][COUNT_W-1:0] counts;
    // Compartment that loses and gains one member for each event.
    logic [2:0] src_of[11] = '{CMP_S, CMP_P, CMP_I1, CMP_IR, CMP_R, CMP_NONE,
                               CMP_R, CMP_P, CMP_S, CMP_IR, CMP_I1};
    logic [2:0] dst_of[11] = '{CMP_I1, CMP_IR, CMP_R, CMP_R, CMP_P, CMP_S,
                               CMP_NONE, CMP_NONE, CMP_NONE, CMP_NONE, CMP_NONE};

    function new();
      errors = 0;
      contact = 226492;
      kappa = 16'd27388;
      recov = 218103808;
      reinf = 521904293;
      waning = 3355443;
      birth = 335544;
      death = 335544;
      pop_cap = COUNT_W'(10000);
      counts = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_CONTACT: contact = data;
        REG_KAPPA:   kappa = data[15:0];
        REG_RECOV:   recov = data;
        REG_REINF:   reinf = data;
        REG_WANING:  waning = data;
        REG_BIRTH:   birth = data;
        REG_DEATH:   death = data;
        REG_POPCAP:  pop_cap = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Truncating product with a right shift, saturated to the rate width.
    function logic [RATE_W-1:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      p = p >> sh;
      return (p > {80'b0, RATE_MAX}) ? RATE_MAX : p[RATE_W-1:0];
    endfunction

    function void note_input(logic req, logic [31:0] draw, logic [4:0][COUNT_W-1:0] ld);
      logic [RATE_W-1:0] r[11];
      logic [63:0]       force_q16, pop;
      logic [RATE_W:0]   sum;
      logic [RATE_W-1:0] tmp, ran;
      logic [2:0]        s, d;
      outcome_t          o;
      o.ev = NO_EVENT;
      o.total = '0;
      if (!req) begin
        counts = ld;
      end else begin
        force_q16 = ({50'b0, counts[CMP_I1]} << 16) + kappa * counts[CMP_IR];
        pop = 64'(counts[0]) + counts[1] + counts[2] + counts[3] + counts[4];
        r[0] = scaled_product(scaled_product(contact, counts[CMP_S], 0), force_q16, 16);
        tmp = scaled_product(scaled_product(contact, counts[CMP_P], 0), kappa, 16);
        r[1] = scaled_product(tmp, force_q16, 16);
        r[2] = scaled_product(recov, counts[CMP_I1], 0);
        r[3] = scaled_product(reinf, counts[CMP_IR], 0);
        r[4] = scaled_product(waning, counts[CMP_R], 0);
        // Births stop once the population has reached the cap.
        r[5] = (pop < pop_cap) ? scaled_product(birth, pop, 0) : '0;
        r[6] = scaled_product(death, counts[CMP_R], 0);
        r[7] = scaled_product(death, counts[CMP_P], 0);
        r[8] = scaled_product(death, counts[CMP_S], 0);
        r[9] = scaled_product(death, counts[CMP_IR], 0);
        r[10] = scaled_product(death, counts[CMP_I1], 0);
        sum = '0;
        for (int k = 0; k < 11; k++) begin
          sum = sum + r[k];
          if (sum > RATE_MAX) sum = RATE_MAX;
        end
        o.total = sum[RATE_W-1:0];
        ran = scaled_product(o.total, draw, 32);
        // Direct method: the first rate that the remaining target falls under.
        for (int k = 0; k < 11; k++) begin
          if (o.ev == NO_EVENT) begin
            if (ran < r[k]) o.ev = 4'(k);
            else ran = ran - r[k];
          end
        end
        if (o.ev != NO_EVENT) begin
          s = src_of[o.ev];
          d = dst_of[o.ev];
          if (s != CMP_NONE && counts[s] != 0) counts[s] = counts[s] - COUNT_W'(1);
          if (d != CMP_NONE && counts[d] != COUNT_MAX) counts[d] = counts[d] + COUNT_W'(1);
        end
      end
      o.cnt = counts;
      o.extinct = (counts[CMP_I1] == 0) && (counts[CMP_IR] == 0);
      pending.insert(pending.size(), o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t exp_o;
      string    names[5] = '{"out_susceptible", "out_first_infected", "out_recovered",
                             "out_partial", "out_reinfected"};
      if (pending.size() == 0) begin
        $error("result transfer with no outstanding item");
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.ev !== exp_o.ev) begin
        $error("out_event_code: expected %0d, got %0d", exp_o.ev, got.ev);
        errors++;
      end
      for (int k = 0; k < 5; k++) begin
        if (got.cnt[k] !== exp_o.cnt[k]) begin
          $error("%s: expected %0d, got %0d", names[k], exp_o.cnt[k], got.cnt[k]);
          errors++;
        end
      end
      if (got.total !== exp_o.total) begin
        $error("out_total_rate: expected %0h, got %0h", exp_o.total, got.total);
        errors++;
      end
      if (got.extinct !== exp_o.extinct) begin
        $error("out_extinct: expected %0b, got %0b", exp_o.extinct, got.extinct);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = 1'b0;
  logic [31:0]        in_uniform_draw = '0;
  logic [COUNT_W-1:0] in_load_susceptible = '0;
  logic [COUNT_W-1:0] in_load_first_infected = '0;
  logic [COUNT_W-1:0] in_load_recovered = '0;
  logic [COUNT_W-1:0] in_load_partial = '0;
  logic [COUNT_W-1:0] in_load_reinfected = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_event_code;
  logic [COUNT_W-1:0] out_susceptible, out_first_infected, out_recovered;
  logic [COUNT_W-1:0] out_partial, out_reinfected;
  logic [RATE_W-1:0]  out_total_rate;
  logic               out_extinct;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  gillespie_epidemic_step dut (.*);

  epidemic_scoreboard sb = new();

  // When quiet is set, neither side idles, so transfers run back to back.
  bit quiet = 1'b0;
  // A request for one long receiver hold-off, and its acknowledgment.
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  bit long_hold_on = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: checks each result transfer and decides the stall for the
  // next cycle. Stalls are mostly short with an occasional long one.
  always @(posedge clk) begin
    outcome_t got;
    if (out_valid && !out_stall) begin
      got.ev = out_event_code;
      got.cnt = {out_reinfected, out_partial, out_recovered, out_first_infected,
                 out_susceptible};
      got.total = out_total_rate;
      got.extinct = out_extinct;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
      if (stall_left == 1 && long_hold_on) begin
        long_hold_done <= 1'b1;
        long_hold_on <= 1'b0;
      end
    end else if (long_hold_req && !long_hold_done) begin
      // Hold the result side off long enough that the sender is stalled too.
      stall_left <= 400;
      long_hold_on <= 1'b1;
      out_stall <= 1'b1;
    end else if (quiet || $urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 3);
      out_stall <= 1'b1;
    end
  end

  // Watchdog: the run is stuck if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one item and holds it until the block takes it, then idles for
  // a random gap. Called aligned to a rising edge and returns aligned too.
  task automatic send_item(logic req, logic [31:0] draw, logic [4:0][COUNT_W-1:0] ld);
    int gap;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_uniform_draw <= draw;
    in_load_susceptible <= ld[0];
    in_load_first_infected <= ld[1];
    in_load_recovered <= ld[2];
    in_load_partial <= ld[3];
    in_load_reinfected <= ld[4];
    do @(posedge clk); while (in_stall);
    sb.note_input(req, draw, ld);
    if (quiet) gap = 0;
    else if ($urandom_range(0, 19) == 0) gap = $urandom_range(15, 60);
    else gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_counts(int s, int i1, int r, int p, int ir);
    send_item(1'b0, $urandom, {ir[13:0], p[13:0], r[13:0], i1[13:0], s[13:0]});
  endtask

  task automatic step_once(logic [31:0] draw);
    logic [4:0][COUNT_W-1:0] junk;
    // The load fields carry noise on a step; the block must ignore them.
    for (int k = 0; k < 5; k++) junk[k] = COUNT_W'($urandom);
    send_item(1'b1, draw, junk);
  endtask

  // Waits until every outstanding result has come back and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] c, logic [31:0] kp, logic [31:0] rc,
                           logic [31:0] rf, logic [31:0] wn, logic [31:0] br,
                           logic [31:0] dr, logic [31:0] cap);
    write_reg(REG_CONTACT, c);
    write_reg(REG_KAPPA, kp);
    write_reg(REG_RECOV, rc);
    write_reg(REG_REINF, rf);
    write_reg(REG_WANING, wn);
    write_reg(REG_BIRTH, br);
    write_reg(REG_DEATH, dr);
    write_reg(REG_POPCAP, cap);
  endtask

  // One random item. Most are steps, since a trajectory only gets deep into
  // the dynamics through many steps from one loaded state. Loads mostly use
  // small realistic counts and sometimes the full field range.
  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      load_counts($urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 12) begin
      load_counts($urandom_range(0, 400), $urandom_range(0, 30), $urandom_range(0, 400),
                  $urandom_range(0, 400), $urandom_range(0, 30));
    end else if (sel < 14) begin
      step_once($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'h0);
    end else begin
      step_once($urandom);
    end
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      // Alternate stretches with and without idling.
      if (k % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      random_item();
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset register values. A step from the reset
    // state has a zero rate sum, so no event is chosen.
    step_once(32'h8000_0000);
    load_counts(0, 0, 0, 0, 0);
    step_once(32'hFFFF_FFFF);
    load_counts(16383, 16383, 16383, 16383, 16383);
    step_once(32'h0);
    step_once(32'hFFFF_FFFF);
    load_counts(100, 5, 20, 30, 2);
    step_once(32'h0);
    step_once(32'hFFFF_FFFF);
    step_once(32'h4000_0000);
    // Extinct: no infected at all, only demographic and waning events.
    load_counts(50, 0, 10, 10, 0);
    step_once(32'hFFFF_FFFF);
    step_once(32'h1234_5678);
    // Population just under and exactly at the birth cap.
    load_counts(9999, 0, 0, 0, 0);
    step_once(32'h0);
    load_counts(10000, 0, 0, 0, 0);
    step_once(32'h0);
    // Only partial susceptibles and reinfected: the reinfection path.
    load_counts(0, 0, 0, 200, 3);
    step_once(32'h0);
    step_once(32'h8000_0000);
    drain();

    // Saturating rates, and an increment at the top of the count range.
    write_all(32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 16383);
    load_counts(16383, 16383, 16383, 16383, 16383);
    step_once(32'h0);
    step_once(32'hFFFF_FFFF);
    load_counts(16382, 0, 0, 0, 0);
    step_once(32'h0);
    step_once(32'h0);
    random_phase(150);

    // All rates zero: every step keeps the counts.
    write_all(0, 0, 0, 0, 0, 0, 0, 0);
    load_counts(300, 20, 100, 50, 4);
    random_phase(60);

    // Realistic epidemic rates near the reset values.
    write_all(226492, 27388, 218103808, 521904293, 3355443, 335544, 335544, 10000);
    load_counts(900, 10, 300, 200, 5);
    random_phase(400);

    // The sender pauses until everything has come back, then the receiver
    // holds off for a long stretch while items keep being offered.
    long_hold_req = 1'b1;
    for (int k = 0; k < 6; k++) step_once($urandom);
    in_valid <= 1'b0;
    while (!long_hold_done) @(posedge clk);
    long_hold_req = 1'b0;
    drain();

    // Strong contact with fast recovery and waning, so every event shows up.
    write_all(32'h0010_0000, 32'h8000, 32'h0100_0000, 32'h0200_0000, 32'h0080_0000,
              32'h0040_0000, 32'h0040_0000, 2000);
    load_counts(300, 20, 100, 100, 5);
    random_phase(450);

    // Fully random register values.
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
    random_phase(250);
    write_all($urandom_range(0, 32'h0100_0000), $urandom, $urandom_range(0, 32'h0400_0000),
              $urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000),
              $urandom_range(0, 32'h0400_0000), $urandom_range(0, 32'h0400_0000),
              $urandom_range(0, 16383));
    load_counts(200, 10, 50, 80, 3);
    random_phase(250);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hdl/gep_pkg.sv
hdl/gep_cfg.sv
hdl/gep_mac.sv
hdl/gillespie_epidemic_step.sv
tb/gillespie_epidemic_step_tb.sv
